[hdl/lcgc_pkg.sv]
// Shared types and constants of the lidar column ground classifier.
package lcgc_pkg;

   localparam int COORD_BITS_DEF = 18;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;
   localparam int HGT_W      = 13;
   localparam int SINE_W     = 15;
   localparam int STEP_W     = 12;
   localparam int FRAC_SHIFT = 30;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SENSOR_HEIGHT = 3'd0,
      REG_FIRST_SINE    = 3'd1,
      REG_STEEP_SINE    = 3'd2,
      REG_GROUND_SINE   = 3'd3,
      REG_FLAT_SINE     = 3'd4,
      REG_HIGH_Z        = 3'd5,
      REG_STEP_UP       = 3'd6,
      REG_LOW_Z         = 3'd7
   } reg_idx_type;

   localparam logic signed [HGT_W-1:0]  RST_SENSOR_HEIGHT = -13'sd1600;
   localparam logic        [SINE_W-1:0] RST_FIRST_SINE    = 15'd2856;
   localparam logic        [SINE_W-1:0] RST_STEEP_SINE    = 15'd11207;
   localparam logic        [SINE_W-1:0] RST_GROUND_SINE   = 15'd5690;
   localparam logic        [SINE_W-1:0] RST_FLAT_SINE     = 15'd858;
   localparam logic signed [HGT_W-1:0]  RST_HIGH_Z        = -13'sd200;
   localparam logic        [STEP_W-1:0] RST_STEP_UP       = 12'd200;
   localparam logic signed [HGT_W-1:0]  RST_LOW_Z         = -13'sd1200;

   // Square steps
   localparam logic [2:0] SQ_DX = 3'd0;
   localparam logic [2:0] SQ_DY = 3'd1;
   localparam logic [2:0] SQ_DZ = 3'd2;
   localparam logic [2:0] SQ_X  = 3'd3;
   localparam logic [2:0] SQ_Y  = 3'd4;

   // Threshold slots
   localparam logic [1:0] THR_MAIN   = 2'd0;  // first-point or steep sine
   localparam logic [1:0] THR_GROUND = 2'd1;
   localparam logic [1:0] THR_FLAT   = 2'd2;

   // Scale phases
   localparam logic [1:0] PH_MUL1 = 2'd0;
   localparam logic [1:0] PH_MUL2 = 2'd1;
   localparam logic [1:0] PH_CMP  = 2'd2;

   typedef struct packed {
      logic       load;
      logic       sq_en;
      logic [2:0] sq_step;
      logic       sc_en;
      logic [1:0] sc_thr;
      logic [1:0] sc_ph;
      logic       commit;
   } cmd_type;

endpackage

[hdl/lcgc_ctrl.sv]
// Sequencer of the classifier: steps the datapath through one point.
module lcgc_ctrl import lcgc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SQUARE = 4'b0010,
      ST_SCALE  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic [1:0] thr_ff, thr_in;
   logic [1:0] ph_ff, ph_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      thr_in   = thr_ff;
      ph_in    = ph_ff;
      cmd      = '0;
      cmd.sq_step = step_ff;
      cmd.sc_thr  = thr_ff;
      cmd.sc_ph   = ph_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = SQ_DX;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.sq_en = 1'b1;
            if (step_ff == SQ_Y) begin
               thr_in   = THR_MAIN;
               ph_in    = PH_MUL1;
               state_in = ST_SCALE;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_SCALE: begin
            cmd.sc_en = 1'b1;
            if (ph_ff == PH_CMP) begin
               ph_in = PH_MUL1;
               if (thr_ff == THR_FLAT) state_in = ST_FINISH;
               else thr_in = thr_ff + 2'd1;
            end else begin
               ph_in = ph_ff + 2'd1;
            end
         end
         ST_FINISH: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.commit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         thr_ff       <= '0;
         ph_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         thr_ff       <= thr_in;
         ph_ff        <= ph_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = reset | (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/lcgc_datapath.sv]
// Datapath of the classifier: registers, shared multipliers, rule decision.
module lcgc_datapath import lcgc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic signed [COORD_BITS-1:0] req_pos_z,
   input  logic                         req_column_start,
   input  logic                         csr_we,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata,
   output logic                         rsp_is_object
);

   localparam int MAGW = ((COORD_BITS > HGT_W) ? COORD_BITS : HGT_W) + 1;
   localparam int SQW  = 2 * MAGW;
   localparam int D2W  = SQW + 2;
   localparam int RW   = SQW + 1;
   localparam int TW   = D2W + SINE_W;
   localparam int UW   = D2W + 2 * SINE_W;
   localparam int EW   = MAGW + 1;

   // configuration
   logic signed [HGT_W-1:0]  sh_ff, hz_ff, lz_ff;
   logic        [SINE_W-1:0] s_first_ff, s_steep_ff, s_ground_ff, s_flat_ff;
   logic        [STEP_W-1:0] step_up_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sh_ff       <= RST_SENSOR_HEIGHT;
         s_first_ff  <= RST_FIRST_SINE;
         s_steep_ff  <= RST_STEEP_SINE;
         s_ground_ff <= RST_GROUND_SINE;
         s_flat_ff   <= RST_FLAT_SINE;
         hz_ff       <= RST_HIGH_Z;
         step_up_ff  <= RST_STEP_UP;
         lz_ff       <= RST_LOW_Z;
      end else if (csr_we) begin
         unique case (reg_idx_type'(csr_index))
            REG_SENSOR_HEIGHT: sh_ff       <= csr_wdata[HGT_W-1:0];
            REG_FIRST_SINE:    s_first_ff  <= csr_wdata;
            REG_STEEP_SINE:    s_steep_ff  <= csr_wdata;
            REG_GROUND_SINE:   s_ground_ff <= csr_wdata;
            REG_FLAT_SINE:     s_flat_ff   <= csr_wdata;
            REG_HIGH_Z:        hz_ff       <= csr_wdata[HGT_W-1:0];
            REG_STEP_UP:       step_up_ff  <= csr_wdata[STEP_W-1:0];
            REG_LOW_Z:         lz_ff       <= csr_wdata[HGT_W-1:0];
            default: ;
         endcase
      end
   end

   // point and history
   logic signed [COORD_BITS-1:0] x_ff, y_ff, z_ff;
   logic                         cs_ff;
   logic signed [COORD_BITS-1:0] last_x_ff, last_y_ff, last_z_ff;
   logic                         last_obj_ff;
   logic [RW-1:0]                r_prev_ff;

   logic [D2W-1:0] d2_ff;
   logic [SQW-1:0] dz2_ff;
   logic [RW-1:0]  r_ff;
   logic [TW-1:0]  t_ff;
   logic [UW-1:0]  u_ff;
   logic [2:0]     ge_ff;
   logic           obj_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff  <= req_pos_x;
         y_ff  <= req_pos_y;
         z_ff  <= req_pos_z;
         cs_ff <= req_column_start;
      end
   end

   // differences and magnitudes
   logic signed [MAGW-1:0] dx_s, dy_s, dz_s, xe, ye;
   logic [MAGW-1:0]        dxm, dym, dzm, xm, ym;

   always_comb begin
      xe = MAGW'(x_ff);
      ye = MAGW'(y_ff);
      if (cs_ff) begin
         dx_s = xe;
         dy_s = ye;
         dz_s = MAGW'(z_ff) - MAGW'(sh_ff);
      end else begin
         dx_s = xe - MAGW'(last_x_ff);
         dy_s = ye - MAGW'(last_y_ff);
         dz_s = MAGW'(z_ff) - MAGW'(last_z_ff);
      end
      dxm = dx_s[MAGW-1] ? MAGW'(-dx_s) : MAGW'(dx_s);
      dym = dy_s[MAGW-1] ? MAGW'(-dy_s) : MAGW'(dy_s);
      dzm = dz_s[MAGW-1] ? MAGW'(-dz_s) : MAGW'(dz_s);
      xm  = xe[MAGW-1] ? MAGW'(-xe) : MAGW'(xe);
      ym  = ye[MAGW-1] ? MAGW'(-ye) : MAGW'(ye);
   end

   // shared squarer
   logic [MAGW-1:0] sq_op;
   logic [SQW-1:0]  sq_prod;

   always_comb begin
      case (cmd.sq_step)
         SQ_DX:   sq_op = dxm;
         SQ_DY:   sq_op = dym;
         SQ_DZ:   sq_op = dzm;
         SQ_X:    sq_op = xm;
         SQ_Y:    sq_op = ym;
         default: sq_op = '0;
      endcase
      sq_prod = sq_op * sq_op;
   end

   always_ff @(posedge clock) begin
      if (cmd.sq_en) begin
         case (cmd.sq_step)
            SQ_DX: d2_ff <= D2W'(sq_prod);
            SQ_DY: d2_ff <= d2_ff + D2W'(sq_prod);
            SQ_DZ: begin
               d2_ff  <= d2_ff + D2W'(sq_prod);
               dz2_ff <= sq_prod;
            end
            SQ_X:    r_ff <= RW'(sq_prod);
            SQ_Y:    r_ff <= r_ff + RW'(sq_prod);
            default: ;
         endcase
      end
   end

   // threshold scaling: d2 * s * s against dz^2 * 2^30
   logic [SINE_W-1:0] s_sel;
   logic [UW-1:0]     dz2_sh;

   always_comb begin
      case (cmd.sc_thr)
         THR_MAIN:   s_sel = cs_ff ? s_first_ff : s_steep_ff;
         THR_GROUND: s_sel = s_ground_ff;
         default:    s_sel = s_flat_ff;
      endcase
      dz2_sh = UW'(dz2_ff) << FRAC_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (cmd.sc_en) begin
         case (cmd.sc_ph)
            PH_MUL1: t_ff <= TW'(d2_ff) * TW'(s_sel);
            PH_MUL2: u_ff <= UW'(t_ff) * UW'(s_sel);
            PH_CMP:  ge_ff[cmd.sc_thr] <= (dz2_sh >= u_ff);
            default: ;
         endcase
      end
   end

   // rule decision
   logic signed [EW-1:0] ze, lze, hze, lowe, upe;
   logic                 dz_pos, obj;

   always_comb begin
      ze     = EW'(z_ff);
      lze    = EW'(last_z_ff);
      hze    = EW'(hz_ff);
      lowe   = EW'(lz_ff);
      upe    = lze + EW'($signed({1'b0, step_up_ff}));
      dz_pos = ~dz_s[MAGW-1];
      if (cs_ff) begin
         obj = (d2_ff != '0) && dz_pos && ge_ff[THR_MAIN];
      end else if (ze > hze) begin
         obj = 1'b1;
      end else if (r_ff <= r_prev_ff) begin
         obj = 1'b1;
      end else if (dz_pos && ge_ff[THR_MAIN]) begin
         obj = 1'b1;
      end else if (!last_obj_ff) begin
         obj = dz_pos && ge_ff[THR_GROUND];
      end else if (ze > upe) begin
         obj = 1'b1;
      end else if (!ge_ff[THR_FLAT] && (ze < lowe)) begin
         obj = 1'b0;
      end else if ((ze < lze) && (ze < lowe)) begin
         obj = 1'b0;
      end else begin
         obj = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_x_ff   <= '0;
         last_y_ff   <= '0;
         last_z_ff   <= '0;
         last_obj_ff <= 1'b1;
         r_prev_ff   <= '0;
      end else if (cmd.commit) begin
         last_x_ff   <= x_ff;
         last_y_ff   <= y_ff;
         last_z_ff   <= z_ff;
         last_obj_ff <= obj;
         r_prev_ff   <= r_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) obj_ff <= obj;
   end

   assign rsp_is_object = obj_ff;

endmodule

[hdl/lidar_column_ground_classifier_top.sv]
// Top level of the lidar column ground classifier.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   req     | req_valid/req_stall, pos_x/y/z, col | in
//   rsp     | rsp_valid/rsp_stall, is_object      | out
//   csr     | csr_valid/csr_ready, index, wdata   | in
//
// One point occupies the sequencer through the accepting (load) step,
// five passes through the shared squarer, three rounds of two scaling
// multiplies and a compare, and a commit step. The result word is valid
// once the result register has taken it at commit; the next point is taken
// only after the previous one is committed.
// A new point is taken only while the sequencer is idle and out of reset.
// The result register lets the next point start while a word waits; commit
// waits while the previous word is still stalled.
// Reset is synchronous: registers return to their defaults, the previous
// point becomes the origin with class object.
module lidar_column_ground_classifier_top import lcgc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic signed [COORD_BITS-1:0] req_pos_z,
   input  logic                         req_column_start,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_is_object,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   cmd_type cmd;

   // registers take a write whenever out of reset
   assign csr_ready = ~reset;

   lcgc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   lcgc_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_column_start (req_column_start),
      .csr_we           (csr_valid & csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_is_object    (rsp_is_object)
   );

endmodule

[tb/sv/lidar_column_ground_classifier_top_tb.sv]
// Self-checking testbench for the lidar column ground classifier top level.
module lidar_column_ground_classifier_top_tb;
   import lcgc_pkg::*;

   localparam int CB = COORD_BITS_DEF;
   localparam int DRAIN_CYCLES = 40;     // a point runs the whole sequence, allow margin
   localparam int STUCK_LIMIT  = 5000;   // cycles with no word moving on any channel

   typedef struct {
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
      logic signed [CB-1:0] z;
      bit                   start;
   } point_type;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic signed [CB-1:0] req_pos_x, req_pos_y, req_pos_z;
   logic req_column_start;
   logic rsp_valid, rsp_stall, rsp_is_object;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lidar_column_ground_classifier_top DUT (.*);

   // Testbench-side copy of the registers and of the previous point
   longint height_mm, high_mm, low_mm, step_mm;
   longint first_sine, steep_sine, ground_sine, flat_sine;
   longint prev_x, prev_y, prev_z;
   bit     prev_obj;

   point_type     points_todo[$];
   bit            flags_due[$];
   idle_mode_type idle_mode;
   int            mismatches, accepted_pts, checked_flags, ground_seen, stuck_cycles;

   // Clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [127:0] square(longint v);
      logic [127:0] m;
      m = (v < 0) ? 128'(-v) : 128'(v);
      return m * m;
   endfunction

   // Sign of dz^2 * 2^30 - s^2 * d2, i.e. |sine| against s/32768
   function automatic int slope_order(longint dz, logic [127:0] d2, longint s);
      logic [127:0] lhs, rhs;
      lhs = square(dz) << FRAC_SHIFT;
      rhs = d2 * 128'(s) * 128'(s);
      return (lhs < rhs) ? -1 : ((lhs > rhs) ? 1 : 0);
   endfunction

   function automatic bit rises_at_least(longint dz, logic [127:0] d2, longint s);
      return (dz >= 0) && (slope_order(dz, d2, s) >= 0);
   endfunction

   // Flag of one point; also makes it the previous point
   function automatic bit classify_point(point_type p);
      longint x, y, z, dz, r_now, r_prev;
      logic [127:0] d2;
      bit obj;
      x = p.x; y = p.y; z = p.z;
      if (p.start) begin
         dz = z - height_mm;
         d2 = square(x) + square(y) + square(dz);
         obj = (d2 == 0) ? 1'b0 : rises_at_least(dz, d2, first_sine);
      end else begin
         dz = z - prev_z;
         d2 = square(x - prev_x) + square(y - prev_y) + square(dz);
         r_now  = x * x + y * y;
         r_prev = prev_x * prev_x + prev_y * prev_y;
         if (z > high_mm)                                   obj = 1;
         else if (r_now <= r_prev)                          obj = 1;
         else if (rises_at_least(dz, d2, steep_sine))       obj = 1;
         else if (!prev_obj)                    obj = rises_at_least(dz, d2, ground_sine);
         else if (z > prev_z + step_mm)                     obj = 1;
         else if (slope_order(dz, d2, flat_sine) < 0 && z < low_mm) obj = 0;
         else if (z < prev_z && z < low_mm)                 obj = 0;
         else                                               obj = 1;
      end
      prev_x = x; prev_y = y; prev_z = z; prev_obj = obj;
      return obj;
   endfunction

   // Point driver: pops pending points, holds a word while stalled
   always @(posedge clock) begin
      point_type nxt;
      bit        go;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         go = 1'b1;
         if (req_valid && !req_stall) begin
            nxt.x = req_pos_x; nxt.y = req_pos_y; nxt.z = req_pos_z;
            nxt.start = req_column_start;
            flags_due.insert(flags_due.size(), classify_point(nxt));
            accepted_pts++;
         end else if (req_valid) begin
            go = 1'b0;   // stalled word stays put
         end
         if (go) begin
            if (points_todo.size() > 0 &&
                !((idle_mode == IDLE_SEND && $urandom_range(0, 99) < 76) ||
                  (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 7))) begin
               nxt = points_todo.pop_front();
               req_pos_x <= nxt.x; req_pos_y <= nxt.y; req_pos_z <= nxt.z;
               req_column_start <= nxt.start;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and receiver stalls
   always @(posedge clock) begin
      bit want;
      if (rsp_valid && !rsp_stall && !reset) begin
         checked_flags++;
         if (flags_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word is_object=%0b", rsp_is_object);
         end else begin
            want = flags_due.pop_front();
            if (!want) ground_seen++;
            if (rsp_is_object !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("is_object mismatch: expected %0b, got %0b", want, rsp_is_object);
            end
         end
      end
      rsp_stall <= (idle_mode == IDLE_RECV && $urandom_range(0, 99) < 76) ||
                   (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 7);
   end

   // Watchdog: work outstanding but no word moving
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready) ||
          (points_todo.size() == 0 && flags_due.size() == 0 && !req_valid && !csr_valid))
         stuck_cycles <= 0;
      else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", STUCK_LIMIT);
         $display("lidar_column_ground_classifier_top_tb NOT OK");
         $finish;
      end else
         stuck_cycles <= stuck_cycles + 1;
   end

   task automatic write_reg(reg_idx_type idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1; csr_index <= idx; csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_SENSOR_HEIGHT: height_mm   = longint'($signed(val[HGT_W-1:0]));
         REG_FIRST_SINE:    first_sine  = longint'(val[SINE_W-1:0]);
         REG_STEEP_SINE:    steep_sine  = longint'(val[SINE_W-1:0]);
         REG_GROUND_SINE:   ground_sine = longint'(val[SINE_W-1:0]);
         REG_FLAT_SINE:     flat_sine   = longint'(val[SINE_W-1:0]);
         REG_HIGH_Z:        high_mm     = longint'($signed(val[HGT_W-1:0]));
         REG_STEP_UP:       step_mm     = longint'(val[STEP_W-1:0]);
         REG_LOW_Z:         low_mm      = longint'($signed(val[HGT_W-1:0]));
         default: ;
      endcase
   endtask

   task automatic add_point(longint x, longint y, longint z, bit start);
      point_type p;
      p.x = CB'(x); p.y = CB'(y); p.z = CB'(z); p.start = start;
      points_todo.insert(points_todo.size(), p);
   endtask

   // Wait for all words to drain, then let the sequencer go quiet
   task automatic drain();
      do @(posedge clock);
      while (points_todo.size() > 0 || req_valid || flags_due.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // A ground-like column walking outward along one direction, plus some noise words
   task automatic add_column(int n);
      longint r, z;
      int cx, cy;
      cx = $urandom_range(0, 32) - 16;
      cy = $urandom_range(0, 32) - 16;
      r  = $urandom_range(1000, 12000);
      z  = height_mm + $urandom_range(0, 400) - 200;
      add_point(r * cx / 16, r * cy / 16, z, 1);
      for (int i = 1; i < n; i++) begin
         if ($urandom_range(0, 99) < 8) begin
            add_point($signed(CB'($urandom)), $signed(CB'($urandom)),
                      $signed(CB'($urandom)), 1'($urandom_range(0, 1)));
         end else begin
            case ($urandom_range(0, 5))
               0:       r = r - $urandom_range(0, 300);           // folds back
               default: r = r + $urandom_range(20, 900);
            endcase
            case ($urandom_range(0, 7))
               0:       z = z + $urandom_range(150, 1500);        // step or steep rise
               1:       z = z - $urandom_range(50, 800);
               2:       z = $urandom_range(0, 8000) - 4000;
               default: z = z + $urandom_range(0, 60) - 30;       // near flat
            endcase
            if (r > 120000) r = 1000;
            add_point(r * cx / 16, r * cy / 16, z, 0);
         end
      end
   endtask

   task automatic write_all_random();
      for (int i = 0; i < 8; i++)
         write_reg(reg_idx_type'(i), CSR_DATA_W'($urandom));
   endtask

   initial begin
      int per_phase;
      reset = 1'b1;
      csr_valid = 1'b0; csr_index = '0; csr_wdata = '0;
      req_pos_x = '0; req_pos_y = '0; req_pos_z = '0; req_column_start = 1'b0;
      idle_mode = IDLE_NONE;
      mismatches = 0; accepted_pts = 0; checked_flags = 0; ground_seen = 0; stuck_cycles = 0;
      height_mm = -1600; first_sine = 2856; steep_sine = 11207; ground_sine = 5690;
      flat_sine = 858; high_mm = -200; step_mm = 200; low_mm = -1200;
      prev_x = 0; prev_y = 0; prev_z = 0; prev_obj = 1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: no column start after reset, sensor foot, coordinate extremes,
      // then a short column that walks through several of the rules
      add_point(1000, 0, -1600, 0);
      add_point(0, 0, -1600, 1);
      add_point(131071, 131071, 131071, 1);
      add_point(-131072, -131072, -131072, 0);
      add_point(-131072, -131072, -131072, 1);
      add_point(131071, -131072, -1600, 0);
      add_point(3000, 0, -1600, 1);
      add_point(3500, 0, -1590, 0);     // ground continues
      add_point(3400, 0, -1600, 0);     // comes back in radially
      add_point(4000, 0, -1200, 0);     // steep
      add_point(4500, 0, -1000, 0);
      add_point(5000, 0, -1650, 0);     // drops below low after object
      add_point(5500, 0, -1640, 0);     // flat band
      add_point(6000, 0, -1300, 0);     // steep rise after ground
      add_point(6100, 0, -100, 0);      // above high
      add_point(-2000, 1500, 4000, 1);  // steep first point
      drain();

      per_phase = 185;
      for (int ph = 0; ph < 8; ph++) begin
         idle_mode = idle_mode_type'(ph % 4);
         case (ph)
            0: ;  // reset values
            1: begin
               write_reg(REG_SENSOR_HEIGHT, CSR_DATA_W'(-4000)); write_reg(REG_FIRST_SINE, 0);
               write_reg(REG_STEEP_SINE, 0); write_reg(REG_GROUND_SINE, 0);
               write_reg(REG_FLAT_SINE, 0); write_reg(REG_HIGH_Z, CSR_DATA_W'(-4000));
               write_reg(REG_STEP_UP, 0); write_reg(REG_LOW_Z, CSR_DATA_W'(-4000));
            end
            2: begin
               write_reg(REG_SENSOR_HEIGHT, 4000); write_reg(REG_FIRST_SINE, 32767);
               write_reg(REG_STEEP_SINE, 32767); write_reg(REG_GROUND_SINE, 32767);
               write_reg(REG_FLAT_SINE, 32767); write_reg(REG_HIGH_Z, 4000);
               write_reg(REG_STEP_UP, 4000); write_reg(REG_LOW_Z, 4000);
            end
            3: begin
               // back to typical values
               write_reg(REG_SENSOR_HEIGHT, CSR_DATA_W'(-1600)); write_reg(REG_FIRST_SINE, 2856);
               write_reg(REG_STEEP_SINE, 11207); write_reg(REG_GROUND_SINE, 5690);
               write_reg(REG_FLAT_SINE, 858); write_reg(REG_HIGH_Z, CSR_DATA_W'(-200));
               write_reg(REG_STEP_UP, 200); write_reg(REG_LOW_Z, CSR_DATA_W'(-1200));
            end
            default: write_all_random();
         endcase
         while (points_todo.size() < per_phase / 2) add_column($urandom_range(3, 24));
         if (ph == 2) drain();   // sender holds off until every flag is back
         while (points_todo.size() < per_phase) add_column($urandom_range(3, 24));
         drain();
      end

      if (flags_due.size() > 0) mismatches += flags_due.size();
      $display("%0d points classified: a directed column and 8 register setting phases",
               accepted_pts);
      $display("%0d flags checked (%0d ground), mismatches: %0d",
               checked_flags, ground_seen, mismatches);
      if (mismatches == 0)
         $display("lidar_column_ground_classifier_top_tb OK");
      else
         $display("lidar_column_ground_classifier_top_tb NOT OK");
      $finish;
   end

endmodule
